// ----- rtl/pddd_pkg.sv -----
// ----------------------------------------------------------------------------
// pddd_pkg
// Types and constants shared by the pulse dial digit decoder.
// ----------------------------------------------------------------------------
package pddd_pkg;

  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned NUM_W    = 64;
  localparam int unsigned IN_TW    = 8;
  localparam int unsigned OUT_TW   = 80;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP = 1'd1;

  localparam logic [TICK_W-1:0]  DIGIT_GAP_RST = 16'd500;
  localparam logic [TICK_W-1:0]  RESET_GAP_RST = 16'd5000;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 16'hFFFF;
  localparam logic [DIGIT_W-1:0] PULSE_MAX     = 4'd15;
  localparam logic [DIGIT_W-1:0] TEN_PULSES    = 4'd10;

  typedef struct packed {
    logic clear_request;
    logic hook_level;
    logic pulse_level;
    logic dial_active;
  } pddd_sample_t;

  typedef struct packed {
    logic [NUM_W-1:0]   number_digits;
    logic [LEN_W-1:0]   number_length;
    logic               number_cleared;
    logic               number_ready;
    logic               store_overflow;
    logic               count_error;
    logic [DIGIT_W-1:0] digit_value;
    logic               digit_valid;
    logic               dialing;
  } pddd_result_t;

  typedef struct packed {
    logic               hook_prev_pressed;
    logic               dial_prev_active;
    logic               pulse_prev_level;
    logic [DIGIT_W-1:0] pulse_counter;
    logic [TICK_W-1:0]  since_digit;
    logic               digit_pending;
    logic [LEN_W-1:0]   stored_count;
  } pddd_state_t;

endpackage

// ----- rtl/pulse_dial_digit_decoder_top.sv -----
// Input register, then result register, between an accepted request and out_tdata.
// Throughput: one request per cycle while out_tready is high; the input register
// refills in the cycle its content moves to the result register.
// Reset (rst_n low, synchronous): number store emptied, hook seen as pressed,
// gap registers back to 500 and 5000 ticks, both channels empty.
// ----------------------------------------------------------------------------
// pulse_dial_digit_decoder_top
// Rotary pulse dial decoder: counts pulse trains into digits and keeps the number.
// ----------------------------------------------------------------------------
module pulse_dial_digit_decoder_top #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] dial_active, [1] pulse_level, [2] hook_level, [3] clear_request, [7:4] zero
  input  logic [pddd_pkg::IN_TW-1:0]          in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] dialing, [1] digit_valid, [5:2] digit_value, [6] count_error,
  // [7] store_overflow, [8] number_ready, [9] number_cleared,
  // [14:10] number_length, [78:15] number_digits, [79] zero
  output logic [pddd_pkg::OUT_TW-1:0]         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pddd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pddd_pkg::TICK_W-1:0]         cfg_data
);
  import pddd_pkg::*;

  localparam int unsigned STORE_W = 4 * MAX_DIGITS;

  logic [TICK_W-1:0]  digit_gap_r;
  logic [TICK_W-1:0]  reset_gap_r;
  pddd_sample_t       sample_r;
  logic               sample_vld_r;
  pddd_state_t        state_r;
  pddd_state_t        state_nxt;
  logic [STORE_W-1:0] store_r;
  logic [STORE_W-1:0] store_nxt;
  pddd_result_t       res;
  pddd_result_t       out_res_r;
  logic               out_vld_r;
  logic               load;
  logic               in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_gap_r <= DIGIT_GAP_RST;
      reset_gap_r <= RESET_GAP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIGIT_GAP: digit_gap_r <= cfg_data;
        CFG_RESET_GAP: reset_gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the input register into the result register whenever it is free
  assign load      = sample_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !sample_vld_r || load;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_vld_r <= 1'b0;
    end else if (in_acc) begin
      sample_vld_r <= 1'b1;
    end else if (load) begin
      sample_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= pddd_sample_t'(in_tdata[3:0]);
    end
  end

  pddd_step #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_step (
    .state     (state_r),
    .store     (store_r),
    .sample    (sample_r),
    .digit_gap (digit_gap_r),
    .reset_gap (reset_gap_r),
    .state_nxt (state_nxt),
    .store_nxt (store_nxt),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.hook_prev_pressed <= 1'b1;
      state_r.dial_prev_active  <= 1'b0;
      state_r.pulse_prev_level  <= 1'b0;
      state_r.pulse_counter     <= '0;
      state_r.since_digit       <= '0;
      state_r.digit_pending     <= 1'b0;
      state_r.stored_count      <= '0;
      store_r                   <= '0;
    end else if (load) begin
      state_r <= state_nxt;
      store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.number_digits, out_res_r.number_length,
                       out_res_r.number_cleared, out_res_r.number_ready,
                       out_res_r.store_overflow, out_res_r.count_error,
                       out_res_r.digit_value, out_res_r.digit_valid, out_res_r.dialing};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stored_count <= LEN_W'(MAX_DIGITS))
    else $error("stored digit count above capacity");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !(res.digit_valid && res.store_overflow) &&
             !(res.digit_valid && res.count_error) &&
             !(res.store_overflow && res.count_error))
    else $error("more than one digit outcome in one tick");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.digit_valid) |-> (res.digit_value <= 4'd9))
    else $error("appended digit out of range");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.digit_valid) |=> (state_r.stored_count != '0) &&
                                  (state_r.since_digit == '0))
    else $error("appended digit not reflected in state");

  a_ready_once: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.number_ready) |=> !state_r.digit_pending)
    else $error("pending ready event kept after firing");
`endif

endmodule

// ----- rtl/pddd_step.sv -----
// ----------------------------------------------------------------------------
// pddd_step
// One-tick update of the dial decoder state and the result it produces.
// ----------------------------------------------------------------------------
module pddd_step #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  pddd_pkg::pddd_state_t             state,
  input  logic [4*MAX_DIGITS-1:0]           store,
  input  pddd_pkg::pddd_sample_t            sample,
  input  logic [pddd_pkg::TICK_W-1:0]       digit_gap,
  input  logic [pddd_pkg::TICK_W-1:0]       reset_gap,
  output pddd_pkg::pddd_state_t             state_nxt,
  output logic [4*MAX_DIGITS-1:0]           store_nxt,
  output pddd_pkg::pddd_result_t            result
);
  import pddd_pkg::*;

  localparam int unsigned STORE_W = 4 * MAX_DIGITS;

  logic [TICK_W-1:0]  since_inc;
  logic               pressed;
  logic               hook_edge;
  logic               clr;
  logic [LEN_W-1:0]   count_c;
  logic [STORE_W-1:0] store_c;
  logic               pending_c;
  logic [DIGIT_W-1:0] pc_start;
  logic               pp_start;
  logic [DIGIT_W-1:0] digit;
  logic               has_digit;
  logic               append;
  logic               ovf;
  logic               cerr;
  logic               ready;

  always_comb begin
    since_inc = (state.since_digit == TICK_MAX) ? state.since_digit
                                                : state.since_digit + 1'b1;
    pressed   = ~sample.hook_level;
    hook_edge = pressed & ~state.hook_prev_pressed;
    clr = (state.stored_count != '0) &&
          (hook_edge || (since_inc > reset_gap) || sample.clear_request);

    count_c   = clr ? '0 : state.stored_count;
    store_c   = clr ? '0 : store;
    pending_c = clr ? 1'b0 : state.digit_pending;

    // restart the pulse train on a fresh dial pull
    pc_start = state.dial_prev_active ? state.pulse_counter : '0;
    pp_start = state.dial_prev_active ? state.pulse_prev_level : 1'b0;

    digit     = (state.pulse_counter == TEN_PULSES) ? '0 : state.pulse_counter;
    has_digit = ~sample.dial_active & state.dial_prev_active &
                (state.pulse_counter != '0) && (state.pulse_counter <= TEN_PULSES);
    cerr      = ~sample.dial_active & state.dial_prev_active &
                (state.pulse_counter > TEN_PULSES);
    append    = has_digit && (count_c < LEN_W'(MAX_DIGITS));
    ovf       = has_digit && !append;

    state_nxt = state;
    state_nxt.hook_prev_pressed = pressed;
    state_nxt.dial_prev_active  = sample.dial_active;
    state_nxt.since_digit       = append ? '0 : since_inc;
    state_nxt.stored_count      = append ? count_c + 1'b1 : count_c;
    store_nxt = append ? ((store_c << DIGIT_W) | STORE_W'(digit)) : store_c;

    if (sample.dial_active) begin
      state_nxt.pulse_counter = (sample.pulse_level && !pp_start && pc_start < PULSE_MAX)
                              ? pc_start + 1'b1 : pc_start;
      state_nxt.pulse_prev_level = sample.pulse_level;
    end else if (state.dial_prev_active) begin
      state_nxt.pulse_counter = '0;
    end

    ready = (state_nxt.stored_count != '0) && (pending_c || append) &&
            (state_nxt.since_digit > digit_gap);
    state_nxt.digit_pending = (pending_c || append) && !ready;

    result.dialing        = sample.dial_active;
    result.digit_valid    = append;
    result.digit_value    = append ? digit : '0;
    result.count_error    = cerr;
    result.store_overflow = ovf;
    result.number_ready   = ready;
    result.number_cleared = clr;
    result.number_length  = state_nxt.stored_count;
    result.number_digits  = NUM_W'(store_nxt);
  end

endmodule
